### src/base64_stream_encoder_macros.svh
// Assertion macros shared by the encoder modules.
// Every property is sampled on the rising clock and is off while reset is held.
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF

// Checks that a property holds at every clock edge outside reset.
`define B64E_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("base64 encoder assertion failed");

// Checks that a condition is never true outside reset.
`define B64E_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("base64 encoder forbidden condition seen");

`else

`define B64E_ASSERT(label, clk, rst_n, prop)
`define B64E_NEVER(label, clk, rst_n, cond)

`endif

`endif

### src/b64e_pkg.sv
package b64e_pkg;

  // Depth of the job queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // ASCII code of the pad character.
  localparam logic [6:0] PAD_CHAR = 7'd61;

  // Most characters that a single byte can produce.
  localparam int MAX_CHARS = 4;

  // One byte's worth of output characters, ready to be sent in order.
  typedef struct packed {
    logic [MAX_CHARS-1:0][6:0] chars;
    logic [1:0]                n_m1;  // number of characters minus one
    logic                      fin;   // the last character ends the message
  } job_t;

  // Maps a six-bit value to its character in the standard alphabet.
  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] ext;
    ext = {1'b0, v};
    if (v < 6'd26) begin
      b64_char = ext + 7'd65;
    end else if (v < 6'd52) begin
      b64_char = ext + 7'd71;
    end else if (v < 6'd62) begin
      b64_char = ext - 7'd4;
    end else if (v == 6'd62) begin
      b64_char = 7'd43;
    end else begin
      b64_char = 7'd47;
    end
  endfunction

endpackage

### src/b64e_in_if.sv
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

### src/b64e_out_if.sv
interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink (input valid, input out_char, input last_char, output ready);
endinterface

### src/b64e_front.sv
`include "base64_stream_encoder_macros.svh"

module b64e_front (
  input  logic          clk,
  input  logic          rst_n,
  b64e_in_if.sink       in_ch,
  input  logic          full,
  output logic          push,
  output b64e_pkg::job_t job
);

  localparam logic [1:0] PH0 = 2'd0;
  localparam logic [1:0] PH1 = 2'd1;
  localparam logic [1:0] PH2 = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;
  logic [7:0] b;
  logic       fin;

  assign b      = in_ch.data_byte;
  assign fin    = in_ch.final_byte;
  assign in_ch.ready = !full;
  assign push   = in_ch.valid && !full;

  // Split the byte into characters according to the position in the group.
  always_comb begin
    phase_nxt = phase_r;
    carry_nxt = carry_r;
    job.chars = {b64e_pkg::MAX_CHARS{b64e_pkg::PAD_CHAR}};
    job.n_m1  = 2'd0;
    job.fin   = fin;
    case (phase_r)
      PH1: begin
        job.chars[0] = b64e_pkg::b64_char({carry_r[1:0], b[7:4]});
        if (fin) begin
          job.chars[1] = b64e_pkg::b64_char({b[3:0], 2'b00});
          job.n_m1     = 2'd2;
        end else begin
          carry_nxt = b[3:0];
          phase_nxt = PH2;
        end
      end
      PH2: begin
        job.chars[0] = b64e_pkg::b64_char({carry_r, b[7:6]});
        job.chars[1] = b64e_pkg::b64_char(b[5:0]);
        job.n_m1     = 2'd1;
        carry_nxt    = 4'd0;
        phase_nxt    = PH0;
      end
      default: begin
        // Start of a group; the unused phase code behaves the same way.
        job.chars[0] = b64e_pkg::b64_char(b[7:2]);
        if (fin) begin
          job.chars[1] = b64e_pkg::b64_char({b[1:0], 4'b0000});
          job.n_m1     = 2'd3;
        end else begin
          carry_nxt = {2'b00, b[1:0]};
          phase_nxt = PH1;
        end
      end
    endcase
    // A final byte closes the message and the next byte opens a new one.
    if (fin) begin
      phase_nxt = PH0;
      carry_nxt = 4'd0;
    end
  end

  // Group position and leftover bits advance on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH0;
      carry_r <= 4'd0;
    end else if (push) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

  `B64E_NEVER(a_phase_legal, clk, rst_n, phase_r == 2'd3)
  `B64E_ASSERT(a_final_restarts, clk, rst_n, (push && fin) |=> (phase_r == PH0 && carry_r == 4'd0))

endmodule

### src/b64e_queue.sv
`include "base64_stream_encoder_macros.svh"

module b64e_queue #(
  parameter int QDEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64e_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output b64e_pkg::job_t pop_job,
  output logic           empty
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  b64e_pkg::job_t entries_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = entries_r[rd_ptr_r];

  // Pointer wrap and occupancy count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Job storage is written at the write pointer.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  `B64E_NEVER(a_no_overflow, clk, rst_n, push && full)
  `B64E_NEVER(a_no_underflow, clk, rst_n, pop && empty)

endmodule

### src/b64e_back.sv
`include "base64_stream_encoder_macros.svh"

module b64e_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           empty,
  input  b64e_pkg::job_t pop_job,
  output logic           pop,
  b64e_out_if.source     out_ch
);

  b64e_pkg::job_t cur_r;
  logic           cur_valid_r;
  logic [1:0]     idx_r;
  logic           out_valid_r;
  logic [6:0]     out_char_r;
  logic           out_last_r;
  logic           out_load;
  logic           cur_done;
  logic           at_end;

  assign out_load = !out_valid_r || out_ch.ready;
  assign at_end   = (idx_r == cur_r.n_m1);
  assign cur_done = cur_valid_r && out_load && at_end;
  assign pop      = !empty && (!cur_valid_r || cur_done);

  // Current job and the index of the next character to send.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= 2'd0;
    end else if (cur_done) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (cur_valid_r && out_load) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= pop_job;
    end
  end

  // Output register: one character per beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= cur_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char_r <= cur_r.chars[idx_r];
      out_last_r <= cur_r.fin && at_end;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_char  = out_char_r;
  assign out_ch.last_char = out_last_r;

  `B64E_ASSERT(a_idx_in_job, clk, rst_n, cur_valid_r |-> (idx_r <= cur_r.n_m1))

endmodule

### src/base64_stream_encoder.sv
// Base64 stream encoder (standard alphabet A-Z a-z 0-9 + /, '=' padding).
// in_ch carries one raw byte per beat in data_byte; final_byte marks the
// last byte of a message. out_ch carries one ASCII character per beat in
// out_char; last_char is set on the final character of the message.
// A byte yields one or two characters; a final byte yields two to four,
// including the pad characters that complete the last group.
// An accepted byte's first character passes the job queue, the current-job
// register and the output register to out_ch. out_ch delivers one character
// per cycle while out_ch.ready is high, four characters per three bytes for
// a long message; the single output register sets that rate.
// A byte enters the job queue in the cycle it is accepted; in_ch.ready drops
// only while the queue is full.
// When the receiver stalls, the current character holds in the output
// register, the queue fills, and then in_ch.ready goes low.
// Reset clears the group position, the leftover bits, the queue and the
// output register; the first byte after reset starts a new message.
module base64_stream_encoder #(
  parameter int QDEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  b64e_in_if.sink    in_ch,
  b64e_out_if.source out_ch
);

  b64e_pkg::job_t push_job;
  b64e_pkg::job_t pop_job;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  // Front: byte splitting and group tracking.
  b64e_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .full  (full),
    .push  (push),
    .job   (push_job)
  );

  // Queue between the two parts.
  b64e_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  // Back: character sequencing and output register.
  b64e_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .empty   (empty),
    .pop_job (pop_job),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // Position of the next byte within its three-byte group.
  typedef enum logic [1:0] {
    GRP_FIRST  = 2'd0,
    GRP_SECOND = 2'd1,
    GRP_THIRD  = 2'd2
  } group_pos_t;

  // One character that the encoder is expected to send.
  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } enc_char_t;

  // Encodes accepted bytes on its own and checks each character against them.
  class b64_scoreboard;
    string      alphabet_str =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    group_pos_t grp_pos;
    logic [3:0] leftover;
    enc_char_t  char_queue[$];
    int         error_count;

    function new();
      grp_pos     = GRP_FIRST;
      leftover    = 4'd0;
      error_count = 0;
    endfunction

    function logic [6:0] char_of(input logic [5:0] v);
      logic [7:0] c;
      c = alphabet_str[v];
      return c[6:0];
    endfunction

    function void push_char(input logic [6:0] code, input logic last);
      enc_char_t e;
      e.code = code;
      e.last = last;
      char_queue.push_back(e);
    endfunction

    // Works out the characters that one accepted byte produces.
    function void note_byte(input logic [7:0] b, input logic fin);
      case (grp_pos)
        GRP_SECOND: begin
          push_char(char_of({leftover[1:0], b[7:4]}), 1'b0);
          if (fin) begin
            push_char(char_of({b[3:0], 2'b00}), 1'b0);
            push_char(b64e_pkg::PAD_CHAR, 1'b1);
          end else begin
            leftover = b[3:0];
            grp_pos  = GRP_THIRD;
          end
        end
        GRP_THIRD: begin
          push_char(char_of({leftover, b[7:6]}), 1'b0);
          push_char(char_of(b[5:0]), fin);
          leftover = 4'd0;
          grp_pos  = GRP_FIRST;
        end
        default: begin
          push_char(char_of(b[7:2]), 1'b0);
          if (fin) begin
            push_char(char_of({b[1:0], 4'b0000}), 1'b0);
            push_char(b64e_pkg::PAD_CHAR, 1'b0);
            push_char(b64e_pkg::PAD_CHAR, 1'b1);
          end else begin
            leftover = {2'b00, b[1:0]};
            grp_pos  = GRP_SECOND;
          end
        end
      endcase
      // A final byte closes the message; the next byte starts a new group.
      if (fin) begin
        leftover = 4'd0;
        grp_pos  = GRP_FIRST;
      end
    endfunction

    // Compares one received character with the oldest expected one.
    function void check_char(input logic [6:0] code, input logic last);
      enc_char_t e;
      if (char_queue.size() == 0) begin
        $display("%0t: character 0x%02h last_char=%0b arrived with nothing expected",
                 $time, code, last);
        error_count++;
      end else begin
        e = char_queue.pop_front();
        if (code !== e.code) begin
          $display("%0t: out_char mismatch: expected 0x%02h, actual 0x%02h",
                   $time, e.code, code);
          error_count++;
        end
        if (last !== e.last) begin
          $display("%0t: last_char mismatch: expected %0b, actual %0b",
                   $time, e.last, last);
          error_count++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  b64e_in_if  in_ch ();
  b64e_out_if out_ch ();

  base64_stream_encoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  b64_scoreboard sb = new();

  // Handshake state sampled mid-cycle, so it holds steady across the next edge.
  logic       rst_n_s;
  logic       in_beat_s;
  logic [7:0] in_byte_s;
  logic       in_fin_s;
  logic       out_beat_s;
  logic [6:0] out_code_s;
  logic       out_last_s;

  // Set for whole messages to give stretches without any idling.
  logic in_calm;
  logic out_calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(negedge clk) begin
    rst_n_s    = rst_n;
    in_beat_s  = in_ch.valid && in_ch.ready;
    in_byte_s  = in_ch.data_byte;
    in_fin_s   = in_ch.final_byte;
    out_beat_s = out_ch.valid && out_ch.ready;
    out_code_s = out_ch.out_char;
    out_last_s = out_ch.last_char;
  end

  // Beats complete at the rising edge; feed them to the scoreboard there.
  always @(posedge clk) begin
    if (rst_n_s === 1'b1) begin
      if (in_beat_s) begin
        sb.note_byte(in_byte_s, in_fin_s);
      end
      if (out_beat_s) begin
        sb.check_char(out_code_s, out_last_s);
      end
    end
  end

  // Receiver: waits a random number of cycles before taking each character.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = out_calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_beat_s);
    end
  end

  // Sends one byte after a random gap and waits until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.final_byte <= fin;
    do @(posedge clk); while (!in_beat_s);
  endtask

  // Sends a whole message; its last byte carries the final mark.
  task automatic send_message(input logic [7:0] msg[$]);
    foreach (msg[i]) begin
      send_byte(msg[i], i == msg.size() - 1);
    end
  endtask

  initial begin
    logic [7:0] msg[$];
    int         n_sent;
    int         len;
    int         wait_cycles;
    enc_char_t  e;

    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= 8'h00;
    in_ch.final_byte <= 1'b0;
    in_calm  = 1'b0;
    out_calm = 1'b0;
    n_sent   = 0;

    @(posedge clk iff rst_n_s === 1'b1);

    // Directed part: a final byte in each group position, all-zero and
    // all-one bytes, and a message that runs across two groups.
    send_message('{8'h00});
    send_message('{8'hFF});
    send_message('{8'hFF, 8'hFF});
    send_message('{8'h00, 8'h00, 8'h00});
    send_message('{8'hFF, 8'hFF, 8'hFF});
    send_message('{8'h4D, 8'h61, 8'h6E});
    send_message('{8'h4D, 8'h61});
    send_message('{8'hFB, 8'hEF, 8'hBE, 8'h00, 8'h10, 8'h83});

    // Random messages, mostly short, now and then a long one.
    while (n_sent < 200) begin
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      msg.delete();
      repeat (len) msg.push_back(8'($urandom_range(0, 255)));
      send_message(msg);
      n_sent += len;
    end
    in_ch.valid <= 1'b0;
    in_calm  = 1'b0;
    out_calm = 1'b0;

    // Drain the outstanding characters, then allow for the pipeline latency.
    wait_cycles = 0;
    while (sb.char_queue.size() > 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);

    while (sb.char_queue.size() > 0) begin
      e = sb.char_queue.pop_front();
      $display("%0t: expected character 0x%02h last_char=%0b never arrived",
               $time, e.code, e.last);
      sb.error_count++;
    end

    if (sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
